@@ rtl/ddg_pkg.sv @@
// Shared types, constants and helper functions for the two-wheel drive gear/PWM controller.
// No dependencies; every other file imports this package.
package ddg_pkg;

    typedef logic [2:0]  t_gear;
    typedef logic [2:0]  t_op;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_u16;
    typedef logic [9:0]  t_trim;
    typedef logic [27:0] t_mul_op;
    typedef logic [55:0] t_prod;
    typedef logic [26:0] t_pt;

    localparam t_gear GEAR_BOTTOM = 3'd0;
    localparam t_gear GEAR_IDLE   = 3'd3;
    localparam t_gear GEAR_TOP    = 3'd6;

    localparam t_op OP_FWD     = 3'd0;
    localparam t_op OP_BWD     = 3'd1;
    localparam t_op OP_LEFT    = 3'd2;
    localparam t_op OP_RIGHT   = 3'd3;
    localparam t_op OP_STOP    = 3'd4;
    localparam t_op OP_RESTORE = 3'd5;

    localparam t_cfg_idx CFG_PERIOD   = 3'd0;
    localparam t_cfg_idx CFG_LTRIM60  = 3'd1;
    localparam t_cfg_idx CFG_LTRIM80  = 3'd2;
    localparam t_cfg_idx CFG_LTRIM100 = 3'd3;
    localparam t_cfg_idx CFG_RTRIM60  = 3'd4;
    localparam t_cfg_idx CFG_RTRIM80  = 3'd5;
    localparam t_cfg_idx CFG_RTRIM100 = 3'd6;

    localparam t_u16  PERIOD_RST = 16'd1000;
    localparam t_trim TRIM_RST   = 10'd1000;

    // Exact reciprocals for quotients of values below 2**27.
    localparam t_mul_op RECIP_1000 = 28'd137438954;   // ceil(2**37 / 1000)
    localparam t_mul_op RECIP_5000 = 28'd219902326;   // ceil(2**40 / 5000)

    localparam t_u16 U16_MAX = 16'hFFFF;

    typedef struct packed {
        logic  write;
        logic  timer;
        t_gear left;
        t_gear right;
    } t_gear_stat;

    // Trim slot for a gear: 0 for 60, 1 for 80, 2 for 100 percent magnitude.
    function automatic logic [1:0] trim_slot(input t_gear g);
        logic [1:0] s;
        if (g > GEAR_IDLE) begin
            s = (g >= GEAR_TOP) ? 2'd2 : 2'(g - 3'd4);
        end else begin
            s = 2'(3'd2 - g);
        end
        return s;
    endfunction

    // Partial-side factor (100 -/+ speed) expressed in units of 20.
    function automatic logic [1:0] part_mult(input t_gear g);
        logic [1:0] m;
        if (g > GEAR_IDLE) begin
            m = (g >= GEAR_TOP) ? 2'd0 : 2'(3'd6 - g);
        end else begin
            m = g[1:0];
        end
        return m;
    endfunction

    function automatic t_u16 sat16(input logic [18:0] v);
        return (v > 19'(U16_MAX)) ? U16_MAX : v[15:0];
    endfunction

endpackage

@@ rtl/ddg_if.sv @@
// Channel interfaces: drive command, drive result and configuration write.
// Depends on ddg_pkg for payload types.
interface ddg_cmd_if;
    import ddg_pkg::*;
    logic  valid;
    logic  ready;
    t_op   op;
    t_u16  hold_ms;
    modport source (output valid, op, hold_ms, input ready);
    modport sink   (input valid, op, hold_ms, output ready);
endinterface

interface ddg_res_if;
    import ddg_pkg::*;
    logic  valid;
    logic  ready;
    t_u16  left_drive_a;
    t_u16  left_drive_b;
    t_u16  right_drive_a;
    t_u16  right_drive_b;
    t_gear left_gear_now;
    t_gear right_gear_now;
    logic  drive_written;
    logic  timer_start;
    t_u16  timer_ms;
    modport source (output valid, left_drive_a, left_drive_b, right_drive_a, right_drive_b,
                    left_gear_now, right_gear_now, drive_written, timer_start, timer_ms,
                    input ready);
    modport sink   (input valid, left_drive_a, left_drive_b, right_drive_a, right_drive_b,
                    left_gear_now, right_gear_now, drive_written, timer_start, timer_ms,
                    output ready);
endinterface

interface ddg_cfg_if;
    import ddg_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_u16     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/ddg_mul.sv @@
// Shared 28x28 multiplier with a registered product.
// Depends on ddg_pkg.
module ddg_mul (
    input  logic            i_clk,
    input  ddg_pkg::t_mul_op i_a,
    input  ddg_pkg::t_mul_op i_b,
    output ddg_pkg::t_prod   o_prod
);
    import ddg_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_a) * t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/ddg_gear.sv @@
// Gear state: current and saved gear pairs, save arming, and per-command flags.
// Depends on ddg_pkg.
module ddg_gear (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_apply,
    input  ddg_pkg::t_op         i_op,
    input  logic                 i_hold_zero,
    output ddg_pkg::t_gear_stat  o_stat
);
    import ddg_pkg::*;

    t_gear r_left, n_left, r_right, n_right;
    t_gear r_sleft, n_sleft, r_sright, n_sright;
    logic  r_armed, n_armed, r_write, n_write, r_timer, n_timer;

    function automatic t_gear toward_idle(input t_gear g);
        t_gear r;
        if (g > GEAR_IDLE) begin
            r = g - 3'd1;
        end else if (g < GEAR_IDLE) begin
            r = g + 3'd1;
        end else begin
            r = g;
        end
        return r;
    endfunction

    always_comb begin
        n_left   = r_left;
        n_right  = r_right;
        n_sleft  = r_sleft;
        n_sright = r_sright;
        n_armed  = r_armed;
        n_write  = r_write;
        n_timer  = r_timer;
        if (i_apply) begin
            n_write = 1'b0;
            n_timer = 1'b0;
            unique case (i_op)
                OP_FWD, OP_BWD: begin
                    if (r_left == r_right) begin
                        if (i_op == OP_FWD && r_left < GEAR_TOP) begin
                            n_left  = r_left + 3'd1;
                            n_right = r_right + 3'd1;
                        end else if (i_op == OP_BWD && r_left > GEAR_BOTTOM) begin
                            n_left  = r_left - 3'd1;
                            n_right = r_right - 3'd1;
                        end
                        n_write = 1'b1;
                    end
                    // save after stepping
                    if (r_armed) begin
                        n_sleft  = n_left;
                        n_sright = n_right;
                        n_armed  = 1'b0;
                    end
                    n_timer = 1'b1;
                end
                OP_LEFT, OP_RIGHT: begin
                    // save before stepping
                    if (r_armed) begin
                        n_sleft  = r_left;
                        n_sright = r_right;
                        n_armed  = 1'b0;
                    end
                    if (r_left == r_right) begin
                        if (i_op == OP_LEFT) begin
                            n_right = toward_idle(r_right);
                        end else begin
                            n_left = toward_idle(r_left);
                        end
                    end
                    n_write = 1'b1;
                    n_timer = 1'b1;
                end
                OP_STOP: begin
                    n_sleft  = GEAR_IDLE;
                    n_sright = GEAR_IDLE;
                    if (!i_hold_zero) begin
                        n_armed = 1'b0;
                        n_timer = 1'b1;
                    end else begin
                        n_left  = GEAR_IDLE;
                        n_right = GEAR_IDLE;
                        n_armed = 1'b1;
                        n_write = 1'b1;
                    end
                end
                OP_RESTORE: begin
                    n_left  = r_sleft;
                    n_right = r_sright;
                    n_armed = 1'b1;
                    n_write = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= GEAR_IDLE;
            r_right  <= GEAR_IDLE;
            r_sleft  <= GEAR_IDLE;
            r_sright <= GEAR_IDLE;
            r_armed  <= 1'b1;
            r_write  <= 1'b0;
            r_timer  <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_right  <= n_right;
            r_sleft  <= n_sleft;
            r_sright <= n_sright;
            r_armed  <= n_armed;
            r_write  <= n_write;
            r_timer  <= n_timer;
        end
    end

    assign o_stat = '{write: r_write, timer: r_timer, left: r_left, right: r_right};

endmodule

@@ rtl/diff_drive_gear_pwm_controller_unit.sv @@
// Top level of the two-wheel drive gear/PWM controller: sequencer, config registers, output register.
// Depends on ddg_pkg, ddg_if.sv, ddg_mul and ddg_gear.
//
// Usage:
//   i_cmd  - drive command transaction (op, hold_ms); ready is high only while idle.
//   o_res  - one result transaction per command: four bridge compare values, the gears,
//            drive_written, timer_start and timer_ms. Drive fields are 0 when not written.
//   i_cfg  - register write transaction (index, data); always ready. Write only while idle.
// Timing: after a command is taken the gear update runs in the command state, then each motor
//   passes through the PT, FULL, PART and STORE states on the one shared multiplier (period*trim, divide by 1000 and by
//   5000 via reciprocal multiply, store), and the done state loads the output register.
//   The result is presented in the first idle cycle, and a new command can be taken at
//   the end of that cycle; no new command is taken while one is still in progress.
// Stall: the result sits in an output register until taken; a finished command that
//   finds the register still full waits in the done state, and no new command is taken.
// Reset: i_rst_n is synchronous, active low. Gears and saved gears return to idle,
//   the save is armed, period resets to 1000 and every trim to 1000.
module diff_drive_gear_pwm_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddg_cmd_if.sink     i_cmd,
    ddg_cfg_if.sink     i_cfg,
    ddg_res_if.source   o_res
);
    import ddg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMD   = 3'd1;
    localparam logic [2:0] ST_PT    = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_PART  = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_side, n_side;
    t_op        r_op;
    t_u16       r_hold;
    t_u16       r_period;
    t_trim      r_trim [6];
    t_pt        r_x, n_x;
    t_u16       r_full, n_full;
    t_u16       r_la, r_lb, r_ra, r_rb;

    logic       r_out_valid;
    t_u16       r_out_la, r_out_lb, r_out_ra, r_out_rb, r_out_tms;
    t_gear      r_out_lg, r_out_rg;
    logic       r_out_wr, r_out_ts;

    t_gear_stat stat;
    t_gear      cur_gear;
    logic [1:0] slot, mult;
    t_trim      trim;
    t_mul_op    mul_a, mul_b;
    t_prod      prod;
    t_u16       partial, drv_a, drv_b;
    logic       cmd_take, load_out;

    assign cmd_take = i_cmd.valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    ddg_gear u_gear (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_apply     (r_state == ST_CMD),
        .i_op        (r_op),
        .i_hold_zero (r_hold == 16'd0),
        .o_stat      (stat)
    );

    ddg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign cur_gear = r_side ? stat.right : stat.left;
    assign slot     = trim_slot(cur_gear);
    assign mult     = part_mult(cur_gear);
    assign trim     = r_trim[3'(r_side) * 3'd3 + 3'(slot)];
    assign partial  = prod[55:40];

    always_comb begin
        if (cur_gear == GEAR_IDLE) begin
            drv_a = r_period;
            drv_b = r_period;
        end else if (cur_gear < GEAR_IDLE) begin
            drv_a = partial;
            drv_b = r_full;
        end else begin
            drv_a = r_full;
            drv_b = partial;
        end
    end

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        n_x     = r_x;
        n_full  = r_full;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_take) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                n_side  = 1'b0;
                n_state = ST_PT;
            end
            ST_PT: begin
                mul_a   = t_mul_op'(r_period);
                mul_b   = t_mul_op'(trim);
                n_state = ST_FULL;
            end
            ST_FULL: begin
                // period*trim is below 2**27; reciprocal gives the exact quotient by 1000
                mul_a   = t_mul_op'(prod[26:0]);
                mul_b   = RECIP_1000;
                n_x     = prod[26:0];
                n_state = ST_PART;
            end
            ST_PART: begin
                n_full = sat16(prod[55:37]);
                unique case (mult)
                    2'd1:    mul_a = t_mul_op'(r_x);
                    2'd2:    mul_a = {r_x, 1'b0};
                    default: mul_a = '0;
                endcase
                mul_b   = RECIP_5000;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = ST_PT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RST;
            for (int k = 0; k < 6; k++) begin
                r_trim[k] <= TRIM_RST;
            end
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_PERIOD:   r_period  <= i_cfg.data;
                    CFG_LTRIM60:  r_trim[0] <= i_cfg.data[9:0];
                    CFG_LTRIM80:  r_trim[1] <= i_cfg.data[9:0];
                    CFG_LTRIM100: r_trim[2] <= i_cfg.data[9:0];
                    CFG_RTRIM60:  r_trim[3] <= i_cfg.data[9:0];
                    CFG_RTRIM80:  r_trim[4] <= i_cfg.data[9:0];
                    CFG_RTRIM100: r_trim[5] <= i_cfg.data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_full <= n_full;
        if (cmd_take) begin
            r_op   <= i_cmd.op;
            r_hold <= i_cmd.hold_ms;
        end
        if (r_state == ST_STORE) begin
            if (!r_side) begin
                r_la <= drv_a;
                r_lb <= drv_b;
            end else begin
                r_ra <= drv_a;
                r_rb <= drv_b;
            end
        end
        if (load_out) begin
            r_out_la  <= stat.write ? r_la : 16'd0;
            r_out_lb  <= stat.write ? r_lb : 16'd0;
            r_out_ra  <= stat.write ? r_ra : 16'd0;
            r_out_rb  <= stat.write ? r_rb : 16'd0;
            r_out_lg  <= stat.left;
            r_out_rg  <= stat.right;
            r_out_wr  <= stat.write;
            r_out_ts  <= stat.timer;
            r_out_tms <= stat.timer ? r_hold : 16'd0;
        end
    end

    assign i_cmd.ready          = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_out_valid;
    assign o_res.left_drive_a   = r_out_la;
    assign o_res.left_drive_b   = r_out_lb;
    assign o_res.right_drive_a  = r_out_ra;
    assign o_res.right_drive_b  = r_out_rb;
    assign o_res.left_gear_now  = r_out_lg;
    assign o_res.right_gear_now = r_out_rg;
    assign o_res.drive_written  = r_out_wr;
    assign o_res.timer_start    = r_out_ts;
    assign o_res.timer_ms       = r_out_tms;

endmodule
